### src/nsp_pkg.sv
// Shared types, codes and character constants for the NMEA sentence parser.
package nsp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SENDER = 3'd1,
    PH_CODE   = 3'd2,
    PH_FIELDS = 3'd3,
    PH_HEXHI  = 3'd4,
    PH_HEXLO  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_PREFIX  = 3'd1,
    KIND_SENDER  = 3'd2,
    KIND_CODE    = 3'd3,
    KIND_CONTENT = 3'd4,
    KIND_SEP     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_PREFIX = 3'd1,
    ERR_END_SENDER = 3'd2,
    ERR_NO_COMMA   = 3'd3,
    ERR_NO_STAR    = 3'd4,
    ERR_CHECKSUM   = 3'd5,
    ERR_TOO_MANY   = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      byte_kind;
    logic [5:0] field_index;
    logic [5:0] field_total;
    logic       sentence_done;
    logic       sentence_valid;
    err_t       error_code;
    logic [7:0] running_checksum;
  } out_word_t;

  // unvalidated hex digit decode, 8-bit wrap
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    return (b <= CH_NINE) ? 8'(b - CH_ZERO) : 8'(b - HEX_ALPHA_OFS);
  endfunction

endpackage

### src/nsp_ifs.sv
// Valid/ready channel interfaces for sentence bytes in and parse results out.
interface nsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       new_sentence;

  modport source (output valid, output char_in, output new_sentence, input ready);
  modport sink (input valid, input char_in, input new_sentence, output ready);
endinterface

interface nsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_kind;
  logic [5:0] field_index;
  logic [5:0] field_total;
  logic       sentence_done;
  logic       sentence_valid;
  logic [2:0] error_code;
  logic [7:0] running_checksum;

  modport source (
    output valid, input ready,
    output out_byte, output byte_kind, output field_index, output field_total,
    output sentence_done, output sentence_valid, output error_code,
    output running_checksum
  );
  modport sink (
    input valid, output ready,
    input out_byte, input byte_kind, input field_index, input field_total,
    input sentence_done, input sentence_valid, input error_code,
    input running_checksum
  );
endinterface

### src/nmea_sentence_parser.sv
// Top level of the NMEA 0183 sentence parser with XOR checksum check.
//
//  channel | dir | handshake   | word
//  in_ch   | in  | valid/ready | char_in[7:0], new_sentence
//  out_ch  | out | valid/ready | out_byte, byte_kind, field_index, field_total,
//          |     |             | sentence_done, sentence_valid, error_code,
//          |     |             | running_checksum
//
// One input word per cycle while in_ch.ready is high; each result word is
// registered in output or skid register; parser state and XOR update on fire.
// Synchronous active-low reset returns the parser to idle with zero totals.
// A two-entry output stage (register plus skid) keeps in_ch.ready high when
// the output first stalls; ready drops only while the skid entry is occupied.
module nmea_sentence_parser import nsp_pkg::*; #(
  parameter int MSG_LEN    = 128,
  parameter int MAX_FIELDS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  nsp_in_if.sink    in_ch,
  nsp_out_if.source out_ch
);

  logic      in_fire;
  out_word_t step_word;
  out_word_t res_word;

  assign in_fire = in_ch.valid && in_ch.ready;

  nsp_step #(
    .MSG_LEN    (MSG_LEN),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .char_in      (in_ch.char_in),
    .new_sentence (in_ch.new_sentence),
    .word         (step_word)
  );

  nsp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (step_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (res_word)
  );

  assign out_ch.out_byte         = res_word.out_byte;
  assign out_ch.byte_kind        = res_word.byte_kind;
  assign out_ch.field_index      = res_word.field_index;
  assign out_ch.field_total      = res_word.field_total;
  assign out_ch.sentence_done    = res_word.sentence_done;
  assign out_ch.sentence_valid   = res_word.sentence_valid;
  assign out_ch.error_code       = res_word.error_code;
  assign out_ch.running_checksum = res_word.running_checksum;

endmodule

### src/nsp_step.sv
// Per-byte parser state machine with XOR accumulator and result word decode.
module nsp_step import nsp_pkg::*; #(
  parameter int MSG_LEN    = 128,
  parameter int MAX_FIELDS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_in,
  input  logic       new_sentence,
  output out_word_t  word
);

  localparam int PW = $clog2(MSG_LEN + 1);
  localparam int FW = $clog2(MAX_FIELDS + 1);

  phase_t        phase_r,  phase_nxt;
  logic [7:0]    xor_r,    xor_nxt;
  logic [PW-1:0] pos_r,    pos_nxt;
  logic [FW-1:0] fields_r, fields_nxt;
  logic [1:0]    sender_r, sender_nxt;
  logic [7:0]    high_r,   high_nxt;
  err_t          err_c;

  logic          in_fields;
  logic [7:0]    dv;
  logic [FW-1:0] fidx_c;
  logic [FW-1:0] fields_show;
  logic [7:0]    xor_show;

  assign dv        = digit_value(char_in);
  assign in_fields = (phase_r == PH_FIELDS) || (phase_r == PH_CODE && char_in == CH_COMMA);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    xor_nxt    = xor_r;
    pos_nxt    = pos_r;
    fields_nxt = fields_r;
    sender_nxt = sender_r;
    high_nxt   = high_r;
    err_c      = ERR_NONE;
    if (new_sentence) begin
      xor_nxt    = '0;
      pos_nxt    = '0;
      fields_nxt = '0;
      sender_nxt = '0;
      high_nxt   = '0;
      if (char_in == CH_DOLLAR || char_in == CH_BANG) begin
        phase_nxt = PH_SENDER;
      end else begin
        phase_nxt = PH_IDLE;
        err_c     = ERR_BAD_PREFIX;
      end
    end else begin
      case (phase_r)
        PH_SENDER: begin
          if (char_in == CH_NUL) begin
            err_c = ERR_END_SENDER;
          end else begin
            xor_nxt    = xor_r ^ char_in;
            pos_nxt    = pos_r + PW'(1);
            sender_nxt = sender_r + 2'd1;
            if (sender_r != 2'd0) begin
              pos_nxt   = PW'(3);
              phase_nxt = PH_CODE;
            end
          end
        end
        PH_CODE: begin
          if (char_in == CH_COMMA) begin
            phase_nxt = PH_FIELDS;
          end else if (char_in == CH_NUL) begin
            err_c = (pos_r == PW'(3)) ? ERR_END_SENDER : ERR_NO_COMMA;
          end else if (pos_r >= PW'(MSG_LEN)) begin
            err_c = ERR_NO_COMMA;
          end else begin
            xor_nxt = xor_r ^ char_in;
            pos_nxt = pos_r + PW'(1);
          end
        end
        PH_HEXHI: begin
          if (char_in == CH_NUL) begin
            err_c = ERR_CHECKSUM;
          end else begin
            high_nxt  = {dv[3:0], 4'b0000};
            phase_nxt = PH_HEXLO;
          end
        end
        PH_HEXLO: begin
          if (char_in == CH_NUL || (high_r | dv) != xor_r) begin
            err_c = ERR_CHECKSUM;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (in_fields) begin
        if (char_in == CH_STAR) begin
          phase_nxt = PH_HEXHI;
        end else if (char_in == CH_NUL || pos_r >= PW'(MSG_LEN)) begin
          err_c = ERR_NO_STAR;
        end else if (char_in == CH_COMMA) begin
          if (fields_r >= FW'(MAX_FIELDS)) begin
            err_c = ERR_TOO_MANY;
          end else begin
            xor_nxt    = xor_r ^ char_in;
            pos_nxt    = pos_r + PW'(1);
            fields_nxt = fields_r + FW'(1);
          end
        end else begin
          xor_nxt = xor_r ^ char_in;
          pos_nxt = pos_r + PW'(1);
        end
      end
    end

    if (err_c != ERR_NONE) begin
      phase_nxt  = PH_IDLE;
      xor_nxt    = '0;
      pos_nxt    = '0;
      fields_nxt = '0;
      sender_nxt = '0;
      high_nxt   = '0;
    end
  end

  // result word
  always_comb begin
    fidx_c      = (fields_r != '0) ? fields_r - FW'(1) : '0;
    fields_show = (err_c != ERR_NONE && !new_sentence) ? fields_r : fields_nxt;
    xor_show    = (err_c != ERR_NONE && !new_sentence) ? xor_r : xor_nxt;

    word                  = '0;
    word.out_byte         = char_in;
    word.byte_kind        = KIND_IGNORED;
    word.error_code       = err_c;
    word.field_total      = 6'(fields_show);
    word.running_checksum = xor_show;

    if (err_c != ERR_NONE) begin
      word.sentence_done = 1'b1;
    end else if (new_sentence) begin
      word.byte_kind = KIND_PREFIX;
    end else begin
      case (phase_r)
        PH_SENDER: word.byte_kind = KIND_SENDER;
        PH_CODE: begin
          word.byte_kind = (char_in == CH_COMMA) ? KIND_SEP : KIND_CODE;
        end
        PH_FIELDS: begin
          if (char_in == CH_COMMA) begin
            word.byte_kind   = KIND_SEP;
            word.field_index = 6'(fields_r);
          end else begin
            word.byte_kind   = (char_in == CH_STAR) ? KIND_SEP : KIND_CONTENT;
            word.field_index = 6'(fidx_c);
          end
        end
        PH_HEXLO: begin
          word.sentence_done  = 1'b1;
          word.sentence_valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      xor_r    <= '0;
      pos_r    <= '0;
      fields_r <= '0;
      sender_r <= '0;
      high_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      pos_r    <= pos_nxt;
      fields_r <= fields_nxt;
      sender_r <= sender_nxt;
      high_r   <= high_nxt;
    end
  end

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && err_c != ERR_NONE |=> phase_r == PH_IDLE && xor_r == '0 && pos_r == '0
                                   && fields_r == '0)
    else $error("state not cleared after error");

  a_valid_idles: assert property (@(posedge clk) disable iff (!rst_n)
    fire && word.sentence_valid |=> phase_r == PH_IDLE && fields_r == $past(fields_r))
    else $error("valid sentence did not return to idle with totals held");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) <= MSG_LEN)
    else $error("position beyond length limit");

  a_fields_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fields_r) <= MAX_FIELDS)
    else $error("field count beyond limit");

endmodule

### src/nsp_skid.sv
// Output register with skid stage between parser and result channel.
module nsp_skid import nsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  out_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_word_r, skid_word_r;
  logic      in_fire;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_word_r <= skid_valid_r ? skid_word_r : in_word;
    end else if (in_fire) begin
      skid_word_r <= in_word;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with output empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && out_valid_r && !out_ready |=> skid_valid_r && skid_word_r == $past(in_word))
    else $error("stalled word not captured in skid");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> !skid_valid_r && out_valid_r
                                  && out_word_r == $past(skid_word_r))
    else $error("skid word not moved to output");

endmodule
